### src/point_segment_distance_unit_defines.svh
// Assertion macros shared by the point to segment distance unit.
`ifndef POINT_SEGMENT_DISTANCE_UNIT_DEFINES_SVH
`define POINT_SEGMENT_DISTANCE_UNIT_DEFINES_SVH

// Antecedent implies consequent in the same cycle.
`define PSD_ASSERT_IMPLY(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("assertion failed");

// Antecedent implies consequent in the next cycle.
`define PSD_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

### src/psd_pkg.sv
// Shared types and constants of the point to segment distance unit.
`timescale 1ns / 1ps
package psd_pkg;

    localparam int COORD_WIDTH_DEF = 32;
    localparam logic [1:0] AXIS_TWO = 2'd2;

    typedef enum logic [1:0] {
        REGION_INTERIOR = 2'd0,
        REGION_START    = 2'd1,
        REGION_END      = 2'd2
    } region_t;

    typedef struct packed {
        logic    degen;
        region_t region;
    } tag_t;

endpackage

### src/point_segment_distance_unit.sv
// Point to segment distance unit, exact floor of the Euclidean distance.
// Pipeline: 6 front stages, 2*COORD_WIDTH+3 divider stages, COORD_WIDTH+2 root stages.
// Throughput: one transaction per cycle; the whole pipeline holds while m_axis stalls.
// Reset: synchronous active-low aresetn clears all valid bits, axis_count returns to 3.
`timescale 1ns / 1ps
`include "point_segment_distance_unit_defines.svh"
module point_segment_distance_unit #(
    parameter int COORD_WIDTH = psd_pkg::COORD_WIDTH_DEF
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_we,
    input  logic [1:0]                          cfg_wdata,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    // point_a_x, point_a_y, point_a_z, seg_start_x/y/z, seg_end_x/y/z
    input  logic [9*COORD_WIDTH-1:0]            s_axis_tdata,
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // distance_out, zero fill
    output logic [((COORD_WIDTH+8)/8)*8-1:0]    m_axis_tdata,
    // nearest_region, degenerate_segment
    output logic [2:0]                          m_axis_tuser
);
    import psd_pkg::*;

    localparam int CW  = COORD_WIDTH;
    localparam int SW  = 2 * (CW + 1) + 1;
    localparam int NW  = 2 * SW;
    localparam int QW  = NW - SW;
    localparam int RW  = SW + (SW % 2);
    localparam int OW  = CW + 1;
    localparam int TDW = ((CW + 8) / 8) * 8;
    localparam int TGW = $bits(tag_t);

    logic [1:0] axis_count_reg;
    logic       en;

    logic              fr_valid;
    logic [NW-1:0]     fr_numer;
    logic [SW-1:0]     fr_denom;
    tag_t              fr_tag;
    logic [SW-1:0]     fr_alt;

    logic              dv_valid;
    logic [QW-1:0]     dv_quot;
    logic [SW+TGW-1:0] dv_side;
    tag_t              dv_tag;
    logic [SW-1:0]     dv_alt;
    logic [RW-1:0]     radicand;

    logic [RW/2-1:0]   root;
    tag_t              out_tag;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            axis_count_reg <= 2'd3;
        end else if (cfg_we) begin
            axis_count_reg <= cfg_wdata;
        end
    end

    assign en            = !m_axis_tvalid || m_axis_tready;
    assign s_axis_tready = en;

    psd_front #(.CW(CW), .SW(SW), .NW(NW)) u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .two_axis  (axis_count_reg == AXIS_TWO),
        .in_valid  (s_axis_tvalid),
        .coords    (s_axis_tdata),
        .out_valid (fr_valid),
        .numer     (fr_numer),
        .denom     (fr_denom),
        .tag       (fr_tag),
        .alt       (fr_alt)
    );

    psd_div #(.NW(NW), .SW(SW), .SIDE_W(SW + TGW)) u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (fr_valid),
        .numer     (fr_numer),
        .denom     (fr_denom),
        .side_in   ({fr_alt, fr_tag}),
        .out_valid (dv_valid),
        .quot      (dv_quot),
        .side_out  (dv_side)
    );

    assign dv_tag   = dv_side[TGW-1:0];
    assign dv_alt   = dv_side[SW+TGW-1:TGW];
    assign radicand = (dv_tag.region == REGION_INTERIOR) ? RW'(dv_quot) : RW'(dv_alt);

    psd_sqrt #(.RW(RW)) u_sqrt (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (dv_valid),
        .radicand  (radicand),
        .tag_in    (dv_tag),
        .out_valid (m_axis_tvalid),
        .root      (root),
        .tag_out   (out_tag)
    );

    assign m_axis_tdata = TDW'(root[OW-1:0]);
    assign m_axis_tuser = {out_tag.degen, out_tag.region};

    `PSD_ASSERT_IMPLY(a_region_code, aclk, aresetn, m_axis_tvalid, m_axis_tuser[1:0] != 2'd3)
    `PSD_ASSERT_IMPLY(a_degen_start, aclk, aresetn, m_axis_tvalid && m_axis_tuser[2],
                      m_axis_tuser[1:0] == REGION_START)
    `PSD_ASSERT_NEXT(a_hold_on_stall, aclk, aresetn, m_axis_tvalid && !m_axis_tready,
                     m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))

endmodule

### src/psd_front.sv
// Front pipeline: differences, dot products, region decision, Lagrange numerator.
`timescale 1ns / 1ps
module psd_front #(
    parameter int CW = psd_pkg::COORD_WIDTH_DEF,
    parameter int SW = 2 * (CW + 1) + 1,
    parameter int NW = 2 * SW
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                en,
    input  logic                two_axis,
    input  logic                in_valid,
    input  logic [8:0][CW-1:0]  coords,
    output logic                out_valid,
    output logic [NW-1:0]       numer,
    output logic [SW-1:0]       denom,
    output psd_pkg::tag_t       tag,
    output logic [SW-1:0]       alt
);
    import psd_pkg::*;

    localparam int DW = CW + 1;
    localparam int PW = 2 * DW;
    localparam int LW = (SW + 1) / 2;
    localparam int HW = SW - LW;

    logic [5:0] vld_reg;

    logic signed [DW-1:0] u_reg [3];
    logic signed [DW-1:0] v_reg [3];
    logic signed [DW-1:0] w_reg [3];

    logic signed [PW-1:0] puu_reg [3];
    logic signed [PW-1:0] puv_reg [3];
    logic signed [PW-1:0] pvv_reg [3];
    logic signed [PW-1:0] pww_reg [3];
    logic                 degen2_reg;

    logic signed [SW-1:0] uu3_reg, uv3_reg, vv3_reg, ww3_reg;
    logic                 degen3_reg;

    logic [2*LW-1:0]    all_reg, bll_reg;
    logic [LW+HW-1:0]   alh_reg, ahl_reg, blh_reg, bhl_reg;
    logic [2*HW-1:0]    ahh_reg, bhh_reg;
    logic [SW-1:0]      uu4_reg, alt4_reg;
    tag_t               tag4_reg;

    logic [NW-1:0]      p1_reg, p2_reg;
    logic [SW-1:0]      uu5_reg, alt5_reg;
    tag_t               tag5_reg;

    logic [NW-1:0]      n6_reg;
    logic [SW-1:0]      uu6_reg, alt6_reg;
    tag_t               tag6_reg;

    logic signed [DW-1:0] u_next [3];
    logic signed [DW-1:0] v_next [3];
    logic signed [DW-1:0] w_next [3];
    logic                 uv_nonpos;
    logic signed [SW-1:0] uu_minus_uv;
    tag_t                 tag4_next;

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            u_next[k] = $signed({coords[6+k][CW-1], coords[6+k]})
                      - $signed({coords[3+k][CW-1], coords[3+k]});
            v_next[k] = $signed({coords[k][CW-1], coords[k]})
                      - $signed({coords[3+k][CW-1], coords[3+k]});
            w_next[k] = $signed({coords[k][CW-1], coords[k]})
                      - $signed({coords[6+k][CW-1], coords[6+k]});
        end
        if (two_axis) begin
            u_next[2] = '0;
            v_next[2] = '0;
            w_next[2] = '0;
        end
    end

    always_comb begin
        uv_nonpos   = uv3_reg[SW-1] || (uv3_reg == '0);
        uu_minus_uv = uu3_reg - uv3_reg;
        tag4_next.degen = degen3_reg;
        if (degen3_reg || uv_nonpos) begin
            tag4_next.region = REGION_START;
        end else if (uu_minus_uv[SW-1]) begin
            tag4_next.region = REGION_END;
        end else begin
            tag4_next.region = REGION_INTERIOR;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (en) begin
            vld_reg <= {vld_reg[4:0], in_valid};
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int k = 0; k < 3; k++) begin
                u_reg[k]   <= u_next[k];
                v_reg[k]   <= v_next[k];
                w_reg[k]   <= w_next[k];
                puu_reg[k] <= u_reg[k] * u_reg[k];
                puv_reg[k] <= u_reg[k] * v_reg[k];
                pvv_reg[k] <= v_reg[k] * v_reg[k];
                pww_reg[k] <= w_reg[k] * w_reg[k];
            end
            degen2_reg <= (u_reg[0] == '0) && (u_reg[1] == '0) && (u_reg[2] == '0);

            uu3_reg <= SW'(puu_reg[0]) + SW'(puu_reg[1]) + SW'(puu_reg[2]);
            uv3_reg <= SW'(puv_reg[0]) + SW'(puv_reg[1]) + SW'(puv_reg[2]);
            vv3_reg <= SW'(pvv_reg[0]) + SW'(pvv_reg[1]) + SW'(pvv_reg[2]);
            ww3_reg <= SW'(pww_reg[0]) + SW'(pww_reg[1]) + SW'(pww_reg[2]);
            degen3_reg <= degen2_reg;

            all_reg  <= vv3_reg[LW-1:0] * uu3_reg[LW-1:0];
            alh_reg  <= vv3_reg[LW-1:0] * uu3_reg[SW-1:LW];
            ahl_reg  <= vv3_reg[SW-1:LW] * uu3_reg[LW-1:0];
            ahh_reg  <= vv3_reg[SW-1:LW] * uu3_reg[SW-1:LW];
            bll_reg  <= uv3_reg[LW-1:0] * uv3_reg[LW-1:0];
            blh_reg  <= uv3_reg[LW-1:0] * uv3_reg[SW-1:LW];
            bhl_reg  <= uv3_reg[SW-1:LW] * uv3_reg[LW-1:0];
            bhh_reg  <= uv3_reg[SW-1:LW] * uv3_reg[SW-1:LW];
            uu4_reg  <= uu3_reg;
            tag4_reg <= tag4_next;
            alt4_reg <= (tag4_next.region == REGION_END) ? ww3_reg : vv3_reg;

            p1_reg <= NW'(all_reg) + (NW'(alh_reg) << LW) + (NW'(ahl_reg) << LW)
                    + (NW'(ahh_reg) << (2 * LW));
            p2_reg <= NW'(bll_reg) + (NW'(blh_reg) << LW) + (NW'(bhl_reg) << LW)
                    + (NW'(bhh_reg) << (2 * LW));
            uu5_reg  <= uu4_reg;
            tag5_reg <= tag4_reg;
            alt5_reg <= alt4_reg;

            n6_reg   <= p1_reg - p2_reg;
            uu6_reg  <= uu5_reg;
            tag6_reg <= tag5_reg;
            alt6_reg <= alt5_reg;
        end
    end

    assign out_valid = vld_reg[5];
    assign numer     = n6_reg;
    assign denom     = uu6_reg;
    assign tag       = tag6_reg;
    assign alt       = alt6_reg;

endmodule

### src/psd_div.sv
// Pipelined restoring divider, one quotient bit per stage.
`timescale 1ns / 1ps
module psd_div #(
    parameter int NW = 134,
    parameter int SW = 67,
    parameter int SIDE_W = 3
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              en,
    input  logic              in_valid,
    input  logic [NW-1:0]     numer,
    input  logic [SW-1:0]     denom,
    input  logic [SIDE_W-1:0] side_in,
    output logic              out_valid,
    output logic [NW-SW-1:0]  quot,
    output logic [SIDE_W-1:0] side_out
);
    localparam int QW = NW - SW;

    logic              vld_reg  [QW];
    logic [SW-1:0]     rem_reg  [QW];
    logic [QW-1:0]     low_reg  [QW];
    logic [QW-1:0]     quo_reg  [QW];
    logic [SW-1:0]     den_reg  [QW];
    logic [SIDE_W-1:0] side_reg [QW];

    for (genvar i = 0; i < QW; i++) begin : g_stage
        logic              vld_src;
        logic [SW-1:0]     rem_src;
        logic [QW-1:0]     low_src;
        logic [QW-1:0]     quo_src;
        logic [SW-1:0]     den_src;
        logic [SIDE_W-1:0] side_src;
        logic [SW:0]       trial;
        logic [SW:0]       diff;

        if (i == 0) begin : g_first
            assign vld_src  = in_valid;
            assign rem_src  = numer[NW-1:QW];
            assign low_src  = numer[QW-1:0];
            assign quo_src  = '0;
            assign den_src  = denom;
            assign side_src = side_in;
        end else begin : g_rest
            assign vld_src  = vld_reg[i-1];
            assign rem_src  = rem_reg[i-1];
            assign low_src  = low_reg[i-1];
            assign quo_src  = quo_reg[i-1];
            assign den_src  = den_reg[i-1];
            assign side_src = side_reg[i-1];
        end

        assign trial = {rem_src, low_src[QW-1]};
        assign diff  = trial - {1'b0, den_src};

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                vld_reg[i] <= 1'b0;
            end else if (en) begin
                vld_reg[i] <= vld_src;
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                rem_reg[i]  <= diff[SW] ? trial[SW-1:0] : diff[SW-1:0];
                low_reg[i]  <= {low_src[QW-2:0], 1'b0};
                quo_reg[i]  <= {quo_src[QW-2:0], ~diff[SW]};
                den_reg[i]  <= den_src;
                side_reg[i] <= side_src;
            end
        end
    end

    assign out_valid = vld_reg[QW-1];
    assign quot      = quo_reg[QW-1];
    assign side_out  = side_reg[QW-1];

endmodule

### src/psd_sqrt.sv
// Pipelined digit-by-digit integer square root, one root bit per stage.
`timescale 1ns / 1ps
module psd_sqrt #(
    parameter int RW = 68
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              en,
    input  logic              in_valid,
    input  logic [RW-1:0]     radicand,
    input  psd_pkg::tag_t     tag_in,
    output logic              out_valid,
    output logic [RW/2-1:0]   root,
    output psd_pkg::tag_t     tag_out
);
    import psd_pkg::*;

    localparam int RTW = RW / 2;
    localparam int MW  = RTW + 2;

    logic          vld_reg [RTW];
    logic [MW-1:0] rem_reg [RTW];
    logic [RW-1:0] x_reg   [RTW];
    logic [RTW-1:0] rt_reg [RTW];
    tag_t          tag_reg [RTW];

    for (genvar i = 0; i < RTW; i++) begin : g_stage
        logic           vld_src;
        logic [MW-1:0]  rem_src;
        logic [RW-1:0]  x_src;
        logic [RTW-1:0] rt_src;
        tag_t           tag_src;
        logic [MW-1:0]  cand;
        logic [MW-1:0]  trial;
        logic [MW:0]    diff;

        if (i == 0) begin : g_first
            assign vld_src = in_valid;
            assign rem_src = '0;
            assign x_src   = radicand;
            assign rt_src  = '0;
            assign tag_src = tag_in;
        end else begin : g_rest
            assign vld_src = vld_reg[i-1];
            assign rem_src = rem_reg[i-1];
            assign x_src   = x_reg[i-1];
            assign rt_src  = rt_reg[i-1];
            assign tag_src = tag_reg[i-1];
        end

        assign cand  = {rem_src[MW-3:0], x_src[RW-1:RW-2]};
        assign trial = {rt_src, 2'b01};
        assign diff  = {1'b0, cand} - {1'b0, trial};

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                vld_reg[i] <= 1'b0;
            end else if (en) begin
                vld_reg[i] <= vld_src;
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                rem_reg[i] <= diff[MW] ? cand : diff[MW-1:0];
                rt_reg[i]  <= {rt_src[RTW-2:0], ~diff[MW]};
                x_reg[i]   <= {x_src[RW-3:0], 2'b00};
                tag_reg[i] <= tag_src;
            end
        end
    end

    assign out_valid = vld_reg[RTW-1];
    assign root      = rt_reg[RTW-1];
    assign tag_out   = tag_reg[RTW-1];

endmodule
